### src/csd_pkg.sv
package csd_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int CYL_W       = 16;
	localparam int TOTAL_W     = 22;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] REG_START_HEAD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISK_END   = 1'd1;

	localparam logic [CYL_W-1:0] START_HEAD_RST = '0;
	localparam logic [CYL_W-1:0] DISK_END_RST   = '1;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_DIST,
		ST_SUM,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PH_UP,
		PH_WRAP,
		PH_LOW
	} phase_t;

endpackage

### src/csd_ram.sv
module csd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/cscan_disk_scheduler.sv
// Requests load at one per cycle while the block is in its load state.
// After the last request of a batch of n stored requests, n + 2 moves follow;
// each move is a scan of the request RAM through one shared key comparator,
// then a distance step, a running-sum step and an emit step that waits for move_ready.
// Reset clears control state and registers; the request RAM is not cleared.
module cscan_disk_scheduler (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [csd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [csd_pkg::CYL_W-1:0]            cfg_data,
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  logic [csd_pkg::CYL_W-1:0]            cylinder,
	input  logic                                 batch_end,
	output logic                                 move_valid,
	input  logic                                 move_ready,
	output logic [csd_pkg::CYL_W-1:0]            from_cylinder,
	output logic [csd_pkg::CYL_W-1:0]            to_cylinder,
	output logic [csd_pkg::CYL_W-1:0]            move_distance,
	output logic [csd_pkg::TOTAL_W-1:0]          total_seek,
	output logic                                 is_wrap,
	output logic                                 final_move
);

	import csd_pkg::*;

	state_t state_q, state_d;
	phase_t phase_q;

	logic [CYL_W-1:0]   start_head_q;
	logic [CYL_W-1:0]   disk_end_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic               cmp_vld_s1;
	logic [IDX_W-1:0]   cmp_idx_s1;
	logic               best_found_q;
	logic [CYL_W:0]     best_key_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [QUEUE_DEPTH-1:0] served_q;
	logic [CYL_W-1:0]   pos_q;
	logic [CYL_W-1:0]   to_q;
	logic [CYL_W-1:0]   dist_q;
	logic [TOTAL_W-1:0] total_q;
	logic               wrap_q;
	logic               final_q;

	logic               req_acc;
	logic               move_acc;
	logic               ram_we;
	logic [CYL_W-1:0]   ram_rdata;
	logic [CYL_W:0]     cand_key;
	logic               take;
	logic               scan_done;
	logic               store_full;

	csd_ram #(
		.WIDTH (CYL_W),
		.DEPTH (QUEUE_DEPTH)
	) u_req_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata (cylinder),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	assign req_acc    = req_valid && req_ready;
	assign move_acc   = move_valid && move_ready;
	assign store_full = (cnt_q == CNT_W'(QUEUE_DEPTH));

	// lower requests sort after all upper ones
	assign cand_key  = {(ram_rdata < start_head_q), ram_rdata};
	assign take      = cmp_vld_s1 && !served_q[cmp_idx_s1] &&
	                   (!best_found_q || (cand_key < best_key_q));
	assign scan_done = (rd_idx_q == cnt_q) && !cmp_vld_s1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: if (req_acc && batch_end) state_d = ST_SCAN;
			ST_SCAN: if (scan_done) state_d = ST_DIST;
			ST_DIST: state_d = ST_SUM;
			ST_SUM:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (move_acc) state_d = final_q ? ST_LOAD : ST_SCAN;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		req_ready  = (state_q == ST_LOAD);
		move_valid = (state_q == ST_EMIT);
		ram_we     = req_acc && !store_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			phase_q      <= PH_UP;
			start_head_q <= START_HEAD_RST;
			disk_end_q   <= DISK_END_RST;
			cnt_q        <= '0;
			rem_q        <= '0;
			rd_idx_q     <= '0;
			cmp_vld_s1   <= 1'b0;
			cmp_idx_s1   <= '0;
			best_found_q <= 1'b0;
			best_key_q   <= '0;
			best_idx_q   <= '0;
			served_q     <= '0;
			pos_q        <= '0;
			to_q         <= '0;
			dist_q       <= '0;
			total_q      <= '0;
			wrap_q       <= 1'b0;
			final_q      <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_index)
					REG_START_HEAD: start_head_q <= cfg_data;
					REG_DISK_END:   disk_end_q   <= cfg_data;
					default: ;
				endcase
			end

			case (state_q)
				ST_LOAD: begin
					if (req_acc) begin
						if (batch_end) begin
							// open the emission pass over this batch
							rem_q        <= store_full ? cnt_q : cnt_q + CNT_W'(1);
							cnt_q        <= store_full ? cnt_q : cnt_q + CNT_W'(1);
							served_q     <= '0;
							phase_q      <= PH_UP;
							pos_q        <= start_head_q;
							total_q      <= '0;
							rd_idx_q     <= '0;
							cmp_vld_s1   <= 1'b0;
							best_found_q <= 1'b0;
						end else if (!store_full) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				ST_SCAN: begin
					if (rd_idx_q != cnt_q) begin
						rd_idx_q   <= rd_idx_q + CNT_W'(1);
						cmp_vld_s1 <= 1'b1;
						cmp_idx_s1 <= rd_idx_q[IDX_W-1:0];
					end else begin
						cmp_vld_s1 <= 1'b0;
					end
					if (take) begin
						best_found_q <= 1'b1;
						best_key_q   <= cand_key;
						best_idx_q   <= cmp_idx_s1;
					end
					if (scan_done) begin
						wrap_q  <= 1'b0;
						final_q <= 1'b0;
						case (phase_q)
							PH_UP: begin
								if (best_found_q && !best_key_q[CYL_W]) begin
									to_q                 <= best_key_q[CYL_W-1:0];
									served_q[best_idx_q] <= 1'b1;
									rem_q                <= rem_q - CNT_W'(1);
								end else begin
									to_q    <= disk_end_q;
									phase_q <= PH_WRAP;
								end
							end
							PH_WRAP: begin
								to_q    <= '0;
								wrap_q  <= 1'b1;
								final_q <= (rem_q == '0);
								phase_q <= PH_LOW;
							end
							PH_LOW: begin
								to_q                 <= best_key_q[CYL_W-1:0];
								served_q[best_idx_q] <= 1'b1;
								rem_q                <= rem_q - CNT_W'(1);
								final_q              <= (rem_q == CNT_W'(1));
							end
							default: phase_q <= PH_UP;
						endcase
					end
				end
				ST_DIST: begin
					dist_q <= (to_q > pos_q) ? (to_q - pos_q) : (pos_q - to_q);
				end
				ST_SUM: begin
					total_q <= total_q + TOTAL_W'(dist_q);
				end
				ST_EMIT: begin
					if (move_acc) begin
						// advance the head and restart the scan
						pos_q        <= to_q;
						rd_idx_q     <= '0;
						cmp_vld_s1   <= 1'b0;
						best_found_q <= 1'b0;
						if (final_q) cnt_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign from_cylinder = pos_q;
	assign to_cylinder   = to_q;
	assign move_distance = dist_q;
	assign total_seek    = total_q;
	assign is_wrap       = wrap_q;
	assign final_move    = final_q;

endmodule
